FILE: rtl/dfne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfne_pkg
// Shared types and constants of the delimited field number extractor.
// ----------------------------------------------------------------------------
package dfne_pkg;

	// default width of the digit accumulator
	localparam int VALUE_WIDTH_DEF = 32;

	// register indexes on the configuration port
	localparam logic [7:0] REG_FIELD_INDEX   = 8'd0;
	localparam logic [7:0] REG_MAX_FIELD_LEN = 8'd1;
	localparam logic [7:0] REG_DELIMITER     = 8'd2;
	localparam logic [7:0] REG_MODE          = 8'd3;

	// field handling modes
	localparam logic [1:0] MODE_INT16  = 2'd0;
	localparam logic [1:0] MODE_INT32  = 2'd1;
	localparam logic [1:0] MODE_QUOTED = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_MISSING = 2'd2;

	// special characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// register settings seen by the parser
	typedef struct packed {
		logic [7:0] field_index;
		logic [7:0] max_field_len;
		logic [7:0] delimiter;
		logic [1:0] mode;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_out;
		logic [31:0] value;
		logic        last;
	} res_t;

endpackage

FILE: rtl/dfne_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfne_cfg_regs
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
module dfne_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [7:0]        wr_index,
	input  logic [7:0]        wr_data,
	output dfne_pkg::cfg_t    cfg
);

	dfne_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_index   <= 8'd0;
			cfg_q.max_field_len <= 8'd9;
			cfg_q.delimiter     <= 8'd44;
			cfg_q.mode          <= dfne_pkg::MODE_INT16;
		end else if (wr_en) begin
			unique case (wr_index)
				dfne_pkg::REG_FIELD_INDEX:   cfg_q.field_index   <= wr_data;
				dfne_pkg::REG_MAX_FIELD_LEN: cfg_q.max_field_len <= wr_data;
				dfne_pkg::REG_DELIMITER:     cfg_q.delimiter     <= wr_data;
				dfne_pkg::REG_MODE:          cfg_q.mode          <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/dfne_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfne_parser
// Per-line parse state and the combinational step that handles one byte.
// ----------------------------------------------------------------------------
module dfne_parser #(
	parameter int VALUE_WIDTH = dfne_pkg::VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        char_in,
	input  logic              line_start,
	input  dfne_pkg::cfg_t    cfg,
	output logic              res_valid,
	output dfne_pkg::res_t    res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SKIP,
		PH_WS,
		PH_DIG,
		PH_QOPEN,
		PH_QSTR,
		PH_DONE
	} phase_t;

	phase_t                   phase_q, ph_n;
	logic [7:0]               delims_q, delims_n;
	logic [7:0]               bytes_q, bytes_n;
	logic [VALUE_WIDTH-1:0]   acc_q, acc_n;
	logic                     neg_q, neg_n;
	logic                     over_q, over_n;

	logic                     emit;
	logic                     emit_num;
	logic [1:0]               kind;
	logic [7:0]               ch_out;
	logic                     last;
	logic                     is_term;
	logic                     is_digit;
	logic                     is_space;
	logic [VALUE_WIDTH-1:0]   digit_val;
	logic [VALUE_WIDTH-1:0]   signed_acc;
	logic [63:0]              sext_acc;
	logic [31:0]              num_value;

	assign is_term  = (char_in == dfne_pkg::CH_CR) || (char_in == dfne_pkg::CH_LF) ||
		(char_in == dfne_pkg::CH_NUL);
	assign is_digit = (char_in >= dfne_pkg::CH_ZERO) && (char_in <= dfne_pkg::CH_NINE);
	assign is_space = (char_in == dfne_pkg::CH_SPACE) || (char_in == dfne_pkg::CH_TAB) ||
		(char_in == dfne_pkg::CH_VT) || (char_in == dfne_pkg::CH_FF);
	assign digit_val = VALUE_WIDTH'(char_in - dfne_pkg::CH_ZERO);

	always_comb begin
		ph_n     = phase_q;
		delims_n = delims_q;
		bytes_n  = bytes_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		over_n   = over_q;
		emit     = 1'b0;
		emit_num = 1'b0;
		kind     = dfne_pkg::KIND_DONE;
		ch_out   = 8'd0;
		last     = 1'b1;

		// a new line restarts from any phase, this byte included
		if (line_start) begin
			delims_n = 8'd0;
			if (cfg.field_index == 8'd0) begin
				bytes_n = 8'd0;
				acc_n   = '0;
				neg_n   = 1'b0;
				over_n  = 1'b0;
				if (cfg.mode == dfne_pkg::MODE_QUOTED) begin
					ph_n = PH_QOPEN;
				end else begin
					ph_n = PH_WS;
					if (cfg.max_field_len == 8'd0) begin
						emit     = 1'b1;
						emit_num = 1'b1;
					end
				end
			end else begin
				ph_n = PH_SKIP;
			end
		end

		if (!emit) begin
			case (ph_n)
				PH_SKIP: begin
					if (char_in == dfne_pkg::CH_NUL) begin
						emit = 1'b1;
						kind = dfne_pkg::KIND_MISSING;
					end else if (char_in == cfg.delimiter) begin
						delims_n = delims_n + 8'd1;
						if (delims_n >= cfg.field_index) begin
							bytes_n = 8'd0;
							acc_n   = '0;
							neg_n   = 1'b0;
							over_n  = 1'b0;
							if (cfg.mode == dfne_pkg::MODE_QUOTED) begin
								ph_n = PH_QOPEN;
							end else begin
								ph_n = PH_WS;
								if (cfg.max_field_len == 8'd0) begin
									emit     = 1'b1;
									emit_num = 1'b1;
								end
							end
						end
					end
				end
				PH_WS, PH_DIG: begin
					if (is_term || char_in == cfg.delimiter) begin
						emit     = 1'b1;
						emit_num = 1'b1;
					end else begin
						// atoi style: blanks, one sign, then digits until a non-digit
						if (!over_n) begin
							if (ph_n == PH_WS) begin
								if (is_space) begin
									ph_n = PH_WS;
								end else if (char_in == dfne_pkg::CH_PLUS ||
									char_in == dfne_pkg::CH_MINUS) begin
									neg_n = (char_in == dfne_pkg::CH_MINUS);
									ph_n  = PH_DIG;
								end else if (is_digit) begin
									acc_n = digit_val;
									ph_n  = PH_DIG;
								end else begin
									over_n = 1'b1;
								end
							end else if (is_digit) begin
								// times ten as two shifted copies
								acc_n = (acc_n << 3) + (acc_n << 1) + digit_val;
							end else begin
								over_n = 1'b1;
							end
						end
						bytes_n = bytes_n + 8'd1;
						if (bytes_n >= cfg.max_field_len) begin
							emit     = 1'b1;
							emit_num = 1'b1;
						end
					end
				end
				PH_QOPEN: begin
					if (char_in != dfne_pkg::CH_QUOTE) begin
						emit = 1'b1;
						kind = dfne_pkg::KIND_MISSING;
					end else if (cfg.max_field_len == 8'd0) begin
						emit = 1'b1;
					end else begin
						bytes_n = 8'd0;
						ph_n    = PH_QSTR;
					end
				end
				PH_QSTR: begin
					if (is_term || char_in == dfne_pkg::CH_QUOTE) begin
						emit = 1'b1;
					end else begin
						bytes_n = bytes_n + 8'd1;
						emit    = 1'b1;
						kind    = dfne_pkg::KIND_CHAR;
						ch_out  = char_in;
						last    = (bytes_n >= cfg.max_field_len);
					end
				end
				default: ;
			endcase
		end

		if (emit && last) begin
			ph_n = PH_DONE;
		end
	end

	// number output: negate, sign-extend from the accumulator width, then trim by mode
	assign signed_acc = neg_n ? (VALUE_WIDTH'(0) - acc_n) : acc_n;
	assign sext_acc   = 64'(signed'(signed_acc));
	assign num_value  = (cfg.mode == dfne_pkg::MODE_INT16) ?
		{{16{sext_acc[15]}}, sext_acc[15:0]} : sext_acc[31:0];

	assign res_valid    = emit;
	assign res.kind     = kind;
	assign res.char_out = ch_out;
	assign res.value    = emit_num ? num_value : 32'd0;
	assign res.last     = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			delims_q <= 8'd0;
			bytes_q  <= 8'd0;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			over_q   <= 1'b0;
		end else if (step_en) begin
			phase_q  <= ph_n;
			delims_q <= delims_n;
			bytes_q  <= bytes_n;
			acc_q    <= acc_n;
			neg_q    <= neg_n;
			over_q   <= over_n;
		end
	end

endmodule

FILE: rtl/delimited_field_number_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_number_extractor
// Picks one delimited field out of a response line and returns it as a
// number or as the characters of a quoted string.
// ----------------------------------------------------------------------------
// Bytes of a response line enter on the slave stream, one per transfer, with
// tuser[0] set on the first byte of each line. The block skips field_index
// delimiters and then either converts the field like atoi (16 or 32 bit
// result, sign-extended) or, in quoted mode, streams out each character
// between the quotes. At most one result leaves per input byte, and the final
// result of a line carries tlast. Throughput is one byte per clock while the
// result stream does not stall: a byte goes from the input register through
// one step of the parser into the result register. The accumulator's
// multiply by ten is a shift-and-add inside that one step.
// Configuration writes should be made while no bytes are in flight.
// ----------------------------------------------------------------------------
module delimited_field_number_extractor #(
	parameter int VALUE_WIDTH = dfne_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic [0:0]  s_tuser,   // [0] line_start
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] char_out, [39:8] value
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	dfne_pkg::cfg_t cfg;
	dfne_pkg::res_t res;
	dfne_pkg::res_t res_q;
	logic           res_valid;

	logic           s1_valid_q;
	logic [7:0]     char_s1;
	logic           ls_s1;
	logic           out_valid_q;
	logic           advance;
	logic           in_xfer;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	dfne_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the held byte moves on once the result register is free or draining
	assign advance  = s1_valid_q & (~out_valid_q | m_tready);
	assign s_tready = ~s1_valid_q | advance;
	assign in_xfer  = s_tvalid & s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_xfer) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= s_tdata;
			ls_s1   <= s_tuser[0];
		end
	end

	dfne_parser #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.char_in    (char_s1),
		.line_start (ls_s1),
		.cfg        (cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register, refilled in the cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance & res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance & res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.value, res_q.char_out};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;

`ifndef SYNTH
	// anything but a string character closes the line
	a_nonchar_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != dfne_pkg::KIND_CHAR |-> m_tlast)
		else $error("non-character result without tlast");

	// character field is zero unless a character is returned
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != dfne_pkg::KIND_CHAR |-> m_tdata[7:0] == 8'd0)
		else $error("char_out set on a non-character result");

	// an empty input register always takes a byte
	a_input_free: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input stalled with empty input register");

	// a string character carries no number
	a_char_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == dfne_pkg::KIND_CHAR |-> m_tdata[39:8] == 32'd0)
		else $error("value set on a character result");
`endif

endmodule
